[sv/cld_pkg.sv]
// Shared types, constants and helpers of the content-length deframer.
// Depends on nothing; cld_front, cld_back, the top level and the bench import it.
package cld_pkg;

   localparam int BYTE_WIDTH          = 8;
   localparam int KIND_WIDTH          = 2;
   localparam int BODY_LENGTH_WIDTH   = 24;
   localparam int MAX_LENGTH_WIDTH    = 24;
   localparam int LENGTH_BITS_DEFAULT = 24;
   localparam int NAME_LEN            = 15;
   localparam int COLUMN_WIDTH        = 5;

   localparam logic [MAX_LENGTH_WIDTH-1:0] MAX_BODY_RESET = '1;

   // result kinds
   localparam logic [KIND_WIDTH-1:0] KIND_BODY   = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_ACCEPT = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_REJECT = 2'd2;

   localparam logic [BYTE_WIDTH-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [BYTE_WIDTH-1:0] CASE_OFFSET  = 8'h20;

   // one classified stream byte, as it sits in the queue
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] raw;
      logic [BYTE_WIDTH-1:0] lower;
      logic                  is_digit;
      logic [3:0]            digit;
      logic                  is_cr;
      logic                  is_lf;
      logic                  is_blank;
      logic                  is_plus;
      logic                  is_minus;
   } cld_item_type;

   // lower-case "content-length:" one character per column
   function automatic logic [BYTE_WIDTH-1:0] length_name_char(input logic [3:0] idx);
      logic [BYTE_WIDTH-1:0] ch;
      ch = 8'h00;
      case (idx)
         4'd0:    ch = 8'h63; // c
         4'd1:    ch = 8'h6F; // o
         4'd2:    ch = 8'h6E; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6E; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2D; // -
         4'd8:    ch = 8'h6C; // l
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6E; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         4'd14:   ch = 8'h3A; // :
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

[sv/cld_channels.sv]
// Valid/ready stream interfaces of the content-length deframer.
// Depends on nothing; payload widths follow the fixed field widths.
interface cld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface cld_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  body_byte;
   logic [23:0] body_length;
   logic        last_of_body;

   modport source (output valid, output result_kind, output body_byte,
                   output body_length, output last_of_body, input ready);
   modport sink   (input valid, input result_kind, input body_byte,
                   input body_length, input last_of_body, output ready);
endinterface

[sv/cld_front.sv]
// Front end: classify each accepted byte and hold it in a two-entry queue.
// Depends on cld_pkg and cld_channels.
module cld_front (
   input  logic                  clock,
   input  logic                  reset,
   cld_req_if.sink               req_stream,
   output logic                  item_valid,
   output cld_pkg::cld_item_type item,
   input  logic                  item_pop
);
   import cld_pkg::*;

   localparam int DEPTH       = 2;
   localparam int PTR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   cld_item_type             entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   cld_item_type             classified;
   logic                     push;
   logic                     pop;
   logic [BYTE_WIDTH-1:0]    b;

   always_comb begin
      b = req_stream.stream_byte;
      classified.raw      = b;
      classified.lower    = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_OFFSET : b;
      classified.is_digit = (b >= CHAR_ZERO && b <= CHAR_NINE);
      classified.digit    = 4'(b - CHAR_ZERO);
      classified.is_cr    = (b == CHAR_CR);
      classified.is_lf    = (b == CHAR_LF);
      classified.is_blank = (b == CHAR_SPACE) || (b == CHAR_TAB);
      classified.is_plus  = (b == CHAR_PLUS);
      classified.is_minus = (b == CHAR_MINUS);
   end

   assign req_stream.ready = (count_ff != COUNT_WIDTH'(DEPTH));
   assign push       = req_stream.valid && req_stream.ready;
   assign item_valid = (count_ff != '0);
   assign pop        = item_pop && item_valid;
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, payload only
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

[sv/cld_back.sv]
// Back end: header parse, length check, body pass-through, result register.
// Depends on cld_pkg and cld_channels; fed by cld_front.
module cld_back #(
   parameter int LENGTH_BITS = cld_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   item_valid,
   input  cld_pkg::cld_item_type                  item,
   output logic                                   item_pop,
   input  logic [cld_pkg::MAX_LENGTH_WIDTH-1:0]   max_body_length,
   cld_rsp_if.source                              rsp_stream
);
   import cld_pkg::*;

   localparam int CMP_WIDTH = (LENGTH_BITS > MAX_LENGTH_WIDTH) ? LENGTH_BITS
                                                               : MAX_LENGTH_WIDTH;
   localparam int WIDE_BITS = LENGTH_BITS + 4;
   localparam logic [LENGTH_BITS-1:0] LEN_LIMIT = '1;

   localparam logic [1:0] PHASE_NONE  = 2'd0;
   localparam logic [1:0] PHASE_BLANK = 2'd1;
   localparam logic [1:0] PHASE_DIGIT = 2'd2;
   localparam logic [1:0] PHASE_ENDED = 2'd3;

   localparam logic [1:0] STATUS_NONE     = 2'd0;
   localparam logic [1:0] STATUS_FOUND    = 2'd1;
   localparam logic [1:0] STATUS_NEGATIVE = 2'd2;
   localparam logic [1:0] STATUS_TOO_BIG  = 2'd3;

   localparam logic [1:0] TERM_NONE  = 2'd0;
   localparam logic [1:0] TERM_CR    = 2'd1;
   localparam logic [1:0] TERM_CRLF  = 2'd2;
   localparam logic [1:0] TERM_CRLFCR = 2'd3;

   localparam logic [COLUMN_WIDTH-1:0] COLUMN_MAX = '1;

   logic                      in_body_ff, in_body_in;
   logic [COLUMN_WIDTH-1:0]   column_ff, column_in;
   logic                      matching_ff, matching_in;
   logic [1:0]                phase_ff, phase_in;
   logic [1:0]                status_ff, status_in;
   logic [LENGTH_BITS-1:0]    acc_ff, acc_in;
   logic [1:0]                term_ff, term_in;
   logic [LENGTH_BITS-1:0]    remaining_ff, remaining_in;

   logic                          out_valid_ff, out_valid_in;
   logic [KIND_WIDTH-1:0]         kind_ff, kind_in;
   logic [BYTE_WIDTH-1:0]         byte_ff, byte_in;
   logic [BODY_LENGTH_WIDTH-1:0]  length_ff, length_in;
   logic                          last_ff, last_in;

   logic                      pop;
   logic                      has_result;
   logic                      prev_cr;
   logic                      header_ok;
   logic                      restart;
   logic                      do_acc;
   logic [WIDE_BITS-1:0]      acc_next;
   logic [LENGTH_BITS-1:0]    remaining_dec;

   assign pop      = item_valid && (!out_valid_ff || rsp_stream.ready);
   assign item_pop = pop;

   always_comb begin
      acc_next = (WIDE_BITS'(acc_ff) << 3) + (WIDE_BITS'(acc_ff) << 1)
               + WIDE_BITS'(item.digit);
      header_ok = (status_ff == STATUS_FOUND) && (acc_ff != '0)
               && (CMP_WIDTH'(acc_ff) <= CMP_WIDTH'(max_body_length));
      remaining_dec = (remaining_ff != '0) ? remaining_ff - 1'b1 : remaining_ff;
      prev_cr = (term_ff == TERM_CR) || (term_ff == TERM_CRLFCR);
   end

   always_comb begin
      in_body_in   = in_body_ff;
      column_in    = column_ff;
      matching_in  = matching_ff;
      phase_in     = phase_ff;
      status_in    = status_ff;
      acc_in       = acc_ff;
      term_in      = term_ff;
      remaining_in = remaining_ff;
      has_result   = 1'b0;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      length_in    = length_ff;
      last_in      = last_ff;
      restart      = 1'b0;
      do_acc       = 1'b0;

      if (pop) begin
         if (in_body_ff) begin
            // pass the body byte, mark the last one
            has_result   = 1'b1;
            kind_in      = KIND_BODY;
            byte_in      = item.raw;
            length_in    = '0;
            last_in      = (remaining_ff <= LENGTH_BITS'(1));
            remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               in_body_in = 1'b0;
               restart    = 1'b1;
            end
         end else if (item.is_lf && term_ff == TERM_CRLFCR) begin
            // end of header: decide
            has_result = 1'b1;
            byte_in    = '0;
            last_in    = 1'b0;
            if (header_ok) begin
               kind_in      = KIND_ACCEPT;
               length_in    = BODY_LENGTH_WIDTH'(acc_ff);
               remaining_in = acc_ff;
               in_body_in   = 1'b1;
            end else begin
               kind_in   = KIND_REJECT;
               length_in = '0;
            end
            restart = 1'b1;
         end else begin
            if (item.is_cr) begin
               term_in = (term_ff == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
            end else if (item.is_lf && term_ff == TERM_CR) begin
               term_in = TERM_CRLF;
            end else begin
               term_in = TERM_NONE;
            end

            if (item.is_lf && prev_cr) begin
               // new line: close any open value
               if (phase_ff == PHASE_BLANK || phase_ff == PHASE_DIGIT) begin
                  phase_in = PHASE_ENDED;
               end
               column_in   = '0;
               matching_in = 1'b1;
            end else begin
               if (phase_ff == PHASE_BLANK) begin
                  if (item.is_blank) begin
                     phase_in = phase_ff;
                  end else if (item.is_plus) begin
                     phase_in = PHASE_DIGIT;
                  end else if (item.is_minus) begin
                     status_in = STATUS_NEGATIVE;
                     phase_in  = PHASE_ENDED;
                  end else if (!item.is_digit) begin
                     phase_in = PHASE_ENDED;
                  end else begin
                     phase_in = PHASE_DIGIT;
                     do_acc   = 1'b1;
                  end
               end else if (phase_ff == PHASE_DIGIT) begin
                  if (!item.is_digit) begin
                     phase_in = PHASE_ENDED;
                  end else begin
                     do_acc = 1'b1;
                  end
               end else if (column_ff < COLUMN_WIDTH'(NAME_LEN) && matching_ff) begin
                  if (item.lower != length_name_char(column_ff[3:0])) begin
                     matching_in = 1'b0;
                  end else if (column_ff == COLUMN_WIDTH'(NAME_LEN - 1)
                               && status_ff == STATUS_NONE) begin
                     status_in = STATUS_FOUND;
                     acc_in    = '0;
                     phase_in  = PHASE_BLANK;
                  end
               end

               // accumulate, saturate on overflow
               if (do_acc && status_ff == STATUS_FOUND) begin
                  if (acc_next[WIDE_BITS-1:LENGTH_BITS] != '0) begin
                     status_in = STATUS_TOO_BIG;
                     acc_in    = LEN_LIMIT;
                  end else begin
                     acc_in = acc_next[LENGTH_BITS-1:0];
                  end
               end

               if (column_ff != COLUMN_MAX) begin
                  column_in = column_ff + 1'b1;
               end
            end
         end

         if (restart) begin
            column_in   = '0;
            matching_in = 1'b1;
            phase_in    = PHASE_NONE;
            status_in   = STATUS_NONE;
            acc_in      = '0;
            term_in     = TERM_NONE;
         end
      end

      if (pop) begin
         out_valid_in = has_result;
      end else begin
         out_valid_in = out_valid_ff && !rsp_stream.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff   <= 1'b0;
         column_ff    <= '0;
         matching_ff  <= 1'b1;
         phase_ff     <= PHASE_NONE;
         status_ff    <= STATUS_NONE;
         acc_ff       <= '0;
         term_ff      <= TERM_NONE;
         remaining_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_body_ff   <= in_body_in;
         column_ff    <= column_in;
         matching_ff  <= matching_in;
         phase_ff     <= phase_in;
         status_ff    <= status_in;
         acc_ff       <= acc_in;
         term_ff      <= term_in;
         remaining_ff <= remaining_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop && has_result) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         length_ff <= length_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_stream.valid        = out_valid_ff;
   assign rsp_stream.result_kind  = kind_ff;
   assign rsp_stream.body_byte    = byte_ff;
   assign rsp_stream.body_length  = length_ff;
   assign rsp_stream.last_of_body = last_ff;

endmodule

[sv/content_length_deframer_unit.sv]
// Top level of the content-length deframer: max-length register, front, back.
// Depends on cld_pkg, cld_channels, cld_front and cld_back.
//
// The block splits a byte stream of framed messages. Each message is a header
// of CRLF-terminated lines closed by CR LF CR LF, then a body. The first header
// line that starts with "Content-Length:" (letters in any case) gives the body
// length: optional spaces or tabs, an optional '+', then decimal digits. On the
// closing CR LF CR LF the block returns one header transaction: accepted with
// the length, or rejected when no length line was seen, the sign was '-', no
// digits came, the value is zero, or it is above max_body_length (or above
// 2^LENGTH_BITS-1). After an accept the next body_length bytes come back as
// body transactions, the final one flagged with last_of_body; then the block
// hunts for the next header. Other bytes give no transaction. Throughput is one
// byte per cycle sustained while the receiver keeps ready high, set by the back
// end updating its state for every byte it pops (compare plus a multiply-by-ten
// accumulate). An accepted byte waits in the front queue until the back end pops
// it, and the back end then registers its result in the result register. The
// two-entry queue and the result register let either side stall briefly without
// stopping the other. Write csr_write_data with csr_write_enable only
// while no transaction is in flight.
module content_length_deframer_unit #(
   parameter int LENGTH_BITS = cld_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   cld_req_if.sink                               req_stream,
   cld_rsp_if.source                             rsp_stream,
   input  logic                                  csr_write_enable,
   input  logic [cld_pkg::MAX_LENGTH_WIDTH-1:0]  csr_write_data
);
   import cld_pkg::*;

   logic [MAX_LENGTH_WIDTH-1:0] max_len_ff, max_len_in;
   logic                        item_valid;
   cld_item_type                item;
   logic                        item_pop;

   // hold the maximum until the next write
   assign max_len_in = csr_write_enable ? csr_write_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_BODY_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // classify and queue accepted bytes
   cld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   // advance the parse state and register results
   cld_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop),
      .max_body_length (max_len_ff),
      .rsp_stream      (rsp_stream)
   );

endmodule

[bench/content_length_deframer_unit_tb.sv]
// Self-checking bench for content_length_deframer_unit: random and directed framed streams.
// Depends on cld_pkg and the cld_req_if / cld_rsp_if interfaces; holds its own tracker package.
package deframer_tb_pkg;
   import cld_pkg::*;

   typedef enum logic [1:0] {VAL_NONE, VAL_BLANKS, VAL_DIGITS, VAL_ENDED} value_phase_type;
   typedef enum logic [1:0] {LEN_NONE, LEN_FOUND, LEN_NEGATIVE, LEN_TOO_LARGE} length_status_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]        kind;
      logic [BYTE_WIDTH-1:0]        data;
      logic [BODY_LENGTH_WIDTH-1:0] length;
      logic                         is_last;
   } frame_result_type;

   localparam string LENGTH_FIELD = "content-length:";
   localparam logic [BODY_LENGTH_WIDTH-1:0] LENGTH_CEILING = '1;
   localparam int COLUMN_LIMIT = 31;

   // Follows the framing state byte by byte and keeps the results still owed.
   class frame_tracker;
      logic [MAX_LENGTH_WIDTH-1:0]  max_len;
      bit                           in_body;
      int                           column;
      bit                           name_ok;
      value_phase_type              vphase;
      length_status_type            lstat;
      logic [BODY_LENGTH_WIDTH-1:0] acc;
      int                           term_seen;
      logic [BODY_LENGTH_WIDTH-1:0] body_left;
      frame_result_type             pending_results[$];
      int                           errors;

      function new();
         max_len   = MAX_BODY_RESET;
         in_body   = 1'b0;
         body_left = '0;
         errors    = 0;
         restart_header();
      endfunction

      function void restart_header();
         column    = 0;
         name_ok   = 1'b1;
         vphase    = VAL_NONE;
         lstat     = LEN_NONE;
         acc       = '0;
         term_seen = 0;
      endfunction

      // note one accepted stream byte
      function void take_byte(logic [BYTE_WIDTH-1:0] b);
         frame_result_type r;
         logic [BYTE_WIDTH-1:0] lc;
         logic [63:0] wide;
         bit prev_cr;
         bit digit;
         bit take;
         r = '0;
         if (in_body) begin
            r.kind    = KIND_BODY;
            r.data    = b;
            r.is_last = (body_left <= 1);
            if (body_left != 0) body_left--;
            if (body_left == 0) begin
               in_body = 1'b0;
               restart_header();
            end
            pending_results.push_back(r);
            return;
         end
         prev_cr = (term_seen == 1 || term_seen == 3);
         if (b == CHAR_LF && term_seen == 3) begin
            if (lstat == LEN_FOUND && acc != 0 && acc <= max_len) begin
               r.kind    = KIND_ACCEPT;
               r.length  = acc;
               body_left = acc;
               in_body   = 1'b1;
            end else begin
               r.kind = KIND_REJECT;
            end
            restart_header();
            pending_results.push_back(r);
            return;
         end
         if (b == CHAR_CR) term_seen = (term_seen == 2) ? 3 : 1;
         else if (b == CHAR_LF && term_seen == 1) term_seen = 2;
         else term_seen = 0;
         if (b == CHAR_LF && prev_cr) begin
            if (vphase == VAL_BLANKS || vphase == VAL_DIGITS) vphase = VAL_ENDED;
            column  = 0;
            name_ok = 1'b1;
            return;
         end
         if (vphase == VAL_BLANKS || vphase == VAL_DIGITS) begin
            digit = (b >= CHAR_ZERO && b <= CHAR_NINE);
            take  = 1'b0;
            if (vphase == VAL_BLANKS) begin
               if (b == CHAR_PLUS) vphase = VAL_DIGITS;
               else if (b == CHAR_MINUS) begin
                  lstat  = LEN_NEGATIVE;
                  vphase = VAL_ENDED;
               end else if (digit) begin
                  vphase = VAL_DIGITS;
                  take   = 1'b1;
               end else if (b != CHAR_SPACE && b != CHAR_TAB) vphase = VAL_ENDED;
            end else if (digit) take = 1'b1;
            else vphase = VAL_ENDED;
            if (take && lstat == LEN_FOUND) begin
               wide = 64'(acc) * 64'd10 + 64'(b - CHAR_ZERO);
               if (wide > 64'(LENGTH_CEILING)) begin
                  lstat = LEN_TOO_LARGE;
                  acc   = LENGTH_CEILING;
               end else begin
                  acc = wide[BODY_LENGTH_WIDTH-1:0];
               end
            end
         end else if (column < NAME_LEN && name_ok) begin
            lc = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_OFFSET : b;
            if (lc != LENGTH_FIELD[column]) name_ok = 1'b0;
            else if (column == NAME_LEN - 1 && lstat == LEN_NONE) begin
               lstat  = LEN_FOUND;
               acc    = '0;
               vphase = VAL_BLANKS;
            end
         end
         if (column < COLUMN_LIMIT) column++;
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      // check one accepted result against the oldest one owed
      function void check_result(frame_result_type got);
         frame_result_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                     $time, got.kind, got.data);
            $display("%0t: unexpected result, actual len %0d last %0b",
                     $time, got.length, got.is_last);
            return;
         end
         want = pending_results.pop_front();
         compare_field("result_kind", 32'(want.kind), 32'(got.kind));
         compare_field("body_byte", 32'(want.data), 32'(got.data));
         compare_field("body_length", 32'(want.length), 32'(got.length));
         compare_field("last_of_body", 32'(want.is_last), 32'(got.is_last));
      endfunction
   endclass
endpackage

module content_length_deframer_unit_tb;
   import cld_pkg::*;
   import deframer_tb_pkg::*;

   localparam int QUIET_LIMIT  = 1000;   // cycles with no transaction before giving up
   localparam int DRAIN_CYCLES = 6;      // pipeline depth plus margin
   localparam int PHASE_BYTES  = 120;

   logic                        clock;
   logic                        reset;
   logic                        csr_write_enable;
   logic [MAX_LENGTH_WIDTH-1:0] csr_write_data;

   cld_req_if req_if();
   cld_rsp_if rsp_if();

   content_length_deframer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_stream       (req_if),
      .rsp_stream       (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   frame_tracker tracker = new();

   logic [BYTE_WIDTH-1:0] frame_bytes[$];  // bytes of the message being built
   int burst_left;
   int byte_count;
   bit rx_on;
   int ready_left;
   int quiet_cycles;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver: alternate ready and stall stretches; some ready stretches are long so
   // the block also runs with no back-pressure at all.
   always @(negedge clock) begin
      if (ready_left == 0) begin
         rx_on = !rx_on;
         if (rx_on) ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                                : $urandom_range(1, 10);
         else ready_left = $urandom_range(1, 6);
      end
      ready_left--;
      rsp_if.ready <= rx_on;
   end

   // Monitor: note accepted bytes first, then check accepted results; a watchdog
   // ends the run when no transaction moves for too long.
   always @(posedge clock) begin : monitor
      frame_result_type got;
      bit req_fire;
      bit rsp_fire;
      if (!reset) begin
         req_fire = req_if.valid && req_if.ready;
         rsp_fire = rsp_if.valid && rsp_if.ready;
         if (req_fire) tracker.take_byte(req_if.stream_byte);
         if (rsp_fire) begin
            got.kind    = rsp_if.result_kind;
            got.data    = rsp_if.body_byte;
            got.length  = rsp_if.body_length;
            got.is_last = rsp_if.last_of_body;
            tracker.check_result(got);
         end
         if (req_fire || rsp_fire) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Drive one byte and hold it until the block takes it. The sender works in bursts;
   // between bursts drop valid for a random gap. Returns on the next falling edge
   // with valid still high so back-to-back bytes never toggle it.
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid       <= 1'b1;
      req_if.stream_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      byte_count++;
      @(negedge clock);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
   endtask

   task automatic add_line_end();
      frame_bytes.push_back(CHAR_CR);
      frame_bytes.push_back(CHAR_LF);
   endtask

   task automatic header_line(input string s);
      add_text(s);
      add_line_end();
   endtask

   // Send the built bytes, then whatever body the header opened, with random content.
   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
      frame_bytes.delete();
      while (tracker.in_body) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic close_header();
      add_line_end();
      send_frame();
   endtask

   // Drop valid and hold until every owed result is back and the pipeline is empty.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_max(input logic [MAX_LENGTH_WIDTH-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tracker.max_len = value;
   endtask

   // Header line of random content, printable mostly; some run past the column limit.
   task automatic add_junk_line();
      int len;
      logic [BYTE_WIDTH-1:0] ch;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 45) : $urandom_range(0, 12);
      repeat (len) begin
         if ($urandom_range(0, 7) == 0) begin
            ch = 8'($urandom_range(0, 255));
            // keep the line intact: flip the top bit of a stray CR or LF
            if (ch == CHAR_CR || ch == CHAR_LF) ch = ch ^ 8'h80;
         end else begin
            ch = 8'($urandom_range(32, 126));
         end
         frame_bytes.push_back(ch);
      end
      add_line_end();
   endtask

   // Length line with random letter case, blanks, sign, value and trailer.
   task automatic add_length_line();
      string value_text;
      logic [63:0] above;
      logic [BYTE_WIDTH-1:0] ch;
      for (int i = 0; i < NAME_LEN; i++) begin
         ch = LENGTH_FIELD[i];
         if (ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) ch = ch - CASE_OFFSET;
         frame_bytes.push_back(ch);
      end
      // now and then spoil one letter of the name
      if ($urandom_range(0, 24) == 0)
         frame_bytes[frame_bytes.size() - 1 - $urandom_range(0, NAME_LEN - 1)] = "#";
      repeat ($urandom_range(0, 3))
         frame_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      case ($urandom_range(0, 19))
         0, 1:    frame_bytes.push_back(CHAR_PLUS);
         2:       frame_bytes.push_back(CHAR_MINUS);
         3: begin
            frame_bytes.push_back(CHAR_PLUS);
            frame_bytes.push_back(CHAR_MINUS);
         end
         default: ;
      endcase
      case ($urandom_range(0, 11))
         0:       value_text = "0";
         1: begin
            // just past the current maximum, so never a long body
            above = 64'(tracker.max_len) + 64'd1 + 64'($urandom_range(0, 999));
            value_text = $sformatf("%0d", above);
         end
         2:       value_text = $sformatf("%0d", {$urandom, $urandom});
         3:       value_text = "";
         default: value_text = $sformatf("%0d", $urandom_range(1, 24));
      endcase
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) frame_bytes.push_back(CHAR_ZERO);
      add_text(value_text);
      if ($urandom_range(0, 4) == 0) add_text(" ;q");
      add_line_end();
   endtask

   // One random message: mostly well-formed headers, some noise and broken endings.
   task automatic send_random_message();
      if ($urandom_range(0, 11) == 0) begin
         repeat ($urandom_range(1, 30)) begin
            case ($urandom_range(0, 3))
               0:       frame_bytes.push_back(CHAR_CR);
               1:       frame_bytes.push_back(CHAR_LF);
               2:       frame_bytes.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
               default: frame_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         send_frame();
         return;
      end
      repeat ($urandom_range(0, 2)) add_junk_line();
      if ($urandom_range(0, 9) != 0) add_length_line();
      repeat ($urandom_range(0, 1)) add_junk_line();
      // a second length line must be ignored
      if ($urandom_range(0, 3) == 0) add_length_line();
      case ($urandom_range(0, 19))
         0: begin
            frame_bytes.push_back(CHAR_CR);
            add_line_end();
         end
         1:       frame_bytes.push_back(CHAR_LF);   // lone LF: header stays open
         default: add_line_end();
      endcase
      send_frame();
   endtask

   // Set the maximum, run random messages, then close any header left open by a broken message.
   task automatic run_phase(input logic [MAX_LENGTH_WIDTH-1:0] max_value);
      int start;
      write_max(max_value);
      start = byte_count;
      while (byte_count - start < PHASE_BYTES) send_random_message();
      add_line_end();
      add_line_end();
      send_frame();
   endtask

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.stream_byte = '0;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      burst_left         = 0;
      byte_count         = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, at the reset maximum.
      header_line("Content-Length: 3");               // plain accept
      close_header();
      header_line("CONTENT-LENGTH:\t +1");            // upper case, tab, plus sign
      close_header();
      close_header();                                 // lone CR LF: an empty first line of the next header
      header_line("content-length: -4");              // negative
      close_header();
      header_line("Content-Length:  ");               // no digits
      close_header();
      header_line("Content-Length: 0");               // zero; later line ignored
      header_line("Content-Length: 2");
      close_header();
      header_line("Content-Length: 16777216");        // one past the width
      close_header();
      header_line("Content-Length: 99999999999999999999");
      close_header();
      add_text("X: y");                               // lone LF is not a line start
      frame_bytes.push_back(CHAR_LF);
      header_line("Content-Length: 2");
      close_header();
      header_line("Host: a");                         // value ended by a letter
      header_line("Content-Length: 2x7");
      close_header();
      header_line("Content-Lengt: 5");                // name one letter short
      close_header();
      header_line("content-LENGTH:007;");             // leading zeros, value ended by ';'
      close_header();

      // Directed maximum checks: at the limit, one above, zero maximum, ceiling.
      write_max(24'd5);
      header_line("Content-Length: 5");
      close_header();
      header_line("Content-Length: 6");
      close_header();
      write_max(24'd0);
      header_line("Content-Length: 1");
      close_header();
      write_max(24'd16777214);
      header_line("Content-Length: 16777215");
      close_header();

      // Random phases across several maximums, extremes among them.
      run_phase(24'd1);
      run_phase(24'd3);
      run_phase(24'd24);
      run_phase(24'($urandom_range(1, 20)));
      run_phase(24'($urandom_range(25, 16777215)));
      run_phase(24'd0);
      run_phase(MAX_BODY_RESET);

      // Drain: wait for every owed result, then let the block sit quiet before the verdict.
      req_if.valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
